// ===== hw/rtl/sit_pkg.sv =====
// shared types and constants for the segment intersection test
// no dependencies
package sit_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef enum logic [1:0] {
        ORIENT_COL = 2'd0,
        ORIENT_CW  = 2'd1,
        ORIENT_CCW = 2'd2
    } t_orient;

endpackage

// ===== hw/rtl/sit_orient.sv =====
// three stage orientation of a point triple: differences, products, sign of cross
// depends on sit_pkg
module sit_orient (
    input  logic             i_clk,
    input  sit_pkg::t_point  i_p,
    input  sit_pkg::t_point  i_q,
    input  sit_pkg::t_point  i_r,
    output sit_pkg::t_orient o_code
);

    logic signed [sit_pkg::DIFF_W-1:0]  r_dy1;
    logic signed [sit_pkg::DIFF_W-1:0]  r_dx2;
    logic signed [sit_pkg::DIFF_W-1:0]  r_dx1;
    logic signed [sit_pkg::DIFF_W-1:0]  r_dy2;
    logic signed [sit_pkg::PROD_W-1:0]  r_m1;
    logic signed [sit_pkg::PROD_W-1:0]  r_m2;
    logic signed [sit_pkg::CROSS_W-1:0] n_cross;
    sit_pkg::t_orient                   n_code;
    sit_pkg::t_orient                   r_code;

    // stage 1: coordinate differences
    always_ff @(posedge i_clk) begin
        r_dy1 <= sit_pkg::DIFF_W'(i_q.y) - sit_pkg::DIFF_W'(i_p.y);
        r_dx2 <= sit_pkg::DIFF_W'(i_r.x) - sit_pkg::DIFF_W'(i_q.x);
        r_dx1 <= sit_pkg::DIFF_W'(i_q.x) - sit_pkg::DIFF_W'(i_p.x);
        r_dy2 <= sit_pkg::DIFF_W'(i_r.y) - sit_pkg::DIFF_W'(i_q.y);
    end

    // stage 2: the two products
    always_ff @(posedge i_clk) begin
        r_m1 <= r_dy1 * r_dx2;
        r_m2 <= r_dx1 * r_dy2;
    end

    // stage 3: sign of the cross product
    always_comb begin
        n_cross = sit_pkg::CROSS_W'(r_m1) - sit_pkg::CROSS_W'(r_m2);
        priority if (n_cross == '0) begin
            n_code = sit_pkg::ORIENT_COL;
        end else if (n_cross[sit_pkg::CROSS_W-1] == 1'b0) begin
            n_code = sit_pkg::ORIENT_CW;
        end else begin
            n_code = sit_pkg::ORIENT_CCW;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

// ===== hw/rtl/sit_box.sv =====
// bounding box test of one point against a segment, delayed to match sit_orient
// depends on sit_pkg
module sit_box (
    input  logic            i_clk,
    input  sit_pkg::t_point i_p,
    input  sit_pkg::t_point i_q,
    input  sit_pkg::t_point i_r,
    output logic            o_inside
);

    logic n_inside;
    logic r_in1;
    logic r_in2;
    logic r_in3;

    // q within [min(p, r), max(p, r)] on both axes
    always_comb begin
        n_inside = ((i_q.x <= i_p.x) || (i_q.x <= i_r.x))
                && ((i_q.x >= i_p.x) || (i_q.x >= i_r.x))
                && ((i_q.y <= i_p.y) || (i_q.y <= i_r.y))
                && ((i_q.y >= i_p.y) || (i_q.y >= i_r.y));
    end

    always_ff @(posedge i_clk) begin
        r_in1 <= n_inside;
        r_in2 <= r_in1;
        r_in3 <= r_in2;
    end

    assign o_inside = r_in3;

endmodule

// ===== hw/rtl/segment_intersection_test.sv =====
// top level of the segment intersection test: four orientation pipes,
// four box tests and the final decision; depends on sit_pkg, sit_orient, sit_box
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | start, busy          | i_a_start_x/y, i_a_end_x/y, i_b_*_x/y
//  result   | o_done (1-cycle)     | o_segments_meet
//
// one beat accepted every cycle; busy stays low
// pipeline registers in order: differences, 17x17 products, cross sign, decision register
// reset clears the valid chain only; data registers carry no reset
// the receiver cannot stall, so the pipeline never holds
module segment_intersection_test (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sit_pkg::t_coord     i_a_start_x,
    input  sit_pkg::t_coord     i_a_start_y,
    input  sit_pkg::t_coord     i_a_end_x,
    input  sit_pkg::t_coord     i_a_end_y,
    input  sit_pkg::t_coord     i_b_start_x,
    input  sit_pkg::t_coord     i_b_start_y,
    input  sit_pkg::t_coord     i_b_end_x,
    input  sit_pkg::t_coord     i_b_end_y,
    output logic                o_done,
    output logic                o_segments_meet
);

    sit_pkg::t_point  as_pt;
    sit_pkg::t_point  ae_pt;
    sit_pkg::t_point  bs_pt;
    sit_pkg::t_point  be_pt;
    sit_pkg::t_orient o1;
    sit_pkg::t_orient o2;
    sit_pkg::t_orient o3;
    sit_pkg::t_orient o4;
    logic             box1;
    logic             box2;
    logic             box3;
    logic             box4;
    logic             n_meet;
    logic             r_meet;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic             r_v4;

    assign as_pt = '{x: i_a_start_x, y: i_a_start_y};
    assign ae_pt = '{x: i_a_end_x,   y: i_a_end_y};
    assign bs_pt = '{x: i_b_start_x, y: i_b_start_y};
    assign be_pt = '{x: i_b_end_x,   y: i_b_end_y};

    sit_orient u_or1 (.i_clk(i_clk), .i_p(as_pt), .i_q(ae_pt), .i_r(bs_pt), .o_code(o1));
    sit_orient u_or2 (.i_clk(i_clk), .i_p(as_pt), .i_q(ae_pt), .i_r(be_pt), .o_code(o2));
    sit_orient u_or3 (.i_clk(i_clk), .i_p(bs_pt), .i_q(be_pt), .i_r(as_pt), .o_code(o3));
    sit_orient u_or4 (.i_clk(i_clk), .i_p(bs_pt), .i_q(be_pt), .i_r(ae_pt), .o_code(o4));

    sit_box u_box1 (.i_clk(i_clk), .i_p(as_pt), .i_q(bs_pt), .i_r(ae_pt), .o_inside(box1));
    sit_box u_box2 (.i_clk(i_clk), .i_p(as_pt), .i_q(be_pt), .i_r(ae_pt), .o_inside(box2));
    sit_box u_box3 (.i_clk(i_clk), .i_p(bs_pt), .i_q(as_pt), .i_r(be_pt), .o_inside(box3));
    sit_box u_box4 (.i_clk(i_clk), .i_p(bs_pt), .i_q(ae_pt), .i_r(be_pt), .o_inside(box4));

    // general crossing or a colinear touch
    always_comb begin
        n_meet = ((o1 != o2) && (o3 != o4))
              || ((o1 == sit_pkg::ORIENT_COL) && box1)
              || ((o2 == sit_pkg::ORIENT_COL) && box2)
              || ((o3 == sit_pkg::ORIENT_COL) && box3)
              || ((o4 == sit_pkg::ORIENT_COL) && box4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meet <= n_meet;
    end

    assign busy            = 1'b0;
    assign o_done          = r_v4;
    assign o_segments_meet = r_meet;

endmodule
